[rtl/bank_mapper_with_cycle_irq_top_assert.svh]
// Assertion macros shared by the RTL of the bank mapper.
// Depends on nothing; the modules that assert include it by file name.
`ifndef BANK_MAPPER_WITH_CYCLE_IRQ_TOP_ASSERT_SVH
`define BANK_MAPPER_WITH_CYCLE_IRQ_TOP_ASSERT_SVH

`ifndef SYNTH
`define BMCI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define BMCI_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMCI_ASSERT(lbl, clk, rstn, prop, msg)
`define BMCI_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

[rtl/bmci_pkg.sv]
// Types, codes and constants of the bank mapper with cycle interrupt counter.
// Used by every module of the block; depends on nothing.
package bmci_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int PRG_SLOTS = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Item kinds.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CPU   = 2'd2;
    localparam logic [1:0] FUNC_PPU   = 2'd3;

    // Translation kinds.
    localparam logic [1:0] KIND_ROM     = 2'd0;
    localparam logic [1:0] KIND_RAM_ON  = 2'd1;
    localparam logic [1:0] KIND_RAM_OFF = 2'd2;
    localparam logic [1:0] KIND_OTHER   = 2'd3;

    // Register commands; codes below CMD_WORK select pattern banks.
    localparam logic [3:0] CMD_WORK   = 4'h8;
    localparam logic [3:0] CMD_PRG0   = 4'h9;
    localparam logic [3:0] CMD_PRG1   = 4'hA;
    localparam logic [3:0] CMD_PRG2   = 4'hB;
    localparam logic [3:0] CMD_MIRROR = 4'hC;
    localparam logic [3:0] CMD_IRQ_EN = 4'hD;
    localparam logic [3:0] CMD_CNT_LO = 4'hE;
    localparam logic [3:0] CMD_CNT_HI = 4'hF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK = 2'd1;

    // Address windows, selected by the top three address bits.
    localparam logic [2:0] WIN_PPU_PAT = 3'b000;
    localparam logic [2:0] WIN_WORK    = 3'b011;
    localparam logic [2:0] WIN_CMD     = 3'b100;
    localparam logic [2:0] WIN_DATA    = 3'b101;
    localparam logic [2:0] WIN_FIXED   = 3'b111;

    localparam logic [7:0]  PRG_MASK_RST  = 8'h0F;
    localparam logic [7:0]  CHR_MASK_RST  = 8'hFF;
    localparam logic [7:0]  WORK_CTRL_RST = 8'h40;
    localparam logic [15:0] COUNT_RELOAD  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic        irq_line;
        logic [1:0]  mirror_mode;
        logic [1:0]  map_kind;
        logic [20:0] mapped_offset;
    } out_item_t;

    // Bank state seen by the address translation.
    typedef struct packed {
        logic [7:0]                 prg_mask;
        logic [7:0]                 chr_mask;
        logic [CHR_SLOTS-1:0][7:0]  chr_bank;
        logic [PRG_SLOTS-1:0][7:0]  prg_bank;
        logic [7:0]                 work_ctrl;
    } bank_state_t;

    // Interrupt and mirroring status after the current item.
    typedef struct packed {
        logic       irq;
        logic [1:0] mirror;
    } post_status_t;

endpackage

[rtl/bmci_regs.sv]
// Mapper register file, configuration masks and the cycle interrupt counter.
// Depends on bmci_pkg.
module bmci_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_en,
    input  bmci_pkg::in_item_t              item,
    input  logic                            cfg_wr_en,
    input  logic [bmci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmci_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bmci_pkg::bank_state_t           bank_state,
    output bmci_pkg::post_status_t          post_status
);
    import bmci_pkg::*;

    logic [7:0]                prg_mask_reg, prg_mask_next;
    logic [7:0]                chr_mask_reg, chr_mask_next;
    logic [3:0]                cmd_reg, cmd_upd, cmd_next;
    logic [CHR_SLOTS-1:0][7:0] chr_reg, chr_upd, chr_next;
    logic [PRG_SLOTS-1:0][7:0] prg_reg, prg_upd, prg_next;
    logic [1:0]                mirror_reg, mirror_upd, mirror_next;
    logic [7:0]                work_reg, work_upd, work_next;
    logic [15:0]               count_reg, count_upd, count_next;
    logic                      en_reg, en_upd, en_next;
    logic                      pend_reg, pend_upd, pend_next;
    logic                      is_load;

    assign is_load = (item.func == FUNC_WRITE) && (item.addr[15:13] == WIN_DATA);

    always_comb begin
        cmd_upd    = cmd_reg;
        chr_upd    = chr_reg;
        prg_upd    = prg_reg;
        mirror_upd = mirror_reg;
        work_upd   = work_reg;
        count_upd  = count_reg;
        en_upd     = en_reg;
        pend_upd   = pend_reg;

        if (item.func == FUNC_WRITE && item.addr[15:13] == WIN_CMD) begin
            cmd_upd = item.data[3:0];
        end

        if (is_load) begin
            unique case (cmd_reg)
                CMD_WORK:   work_upd = item.data;
                CMD_PRG0:   prg_upd[0] = item.data;
                CMD_PRG1:   prg_upd[1] = item.data;
                CMD_PRG2:   prg_upd[2] = item.data;
                CMD_MIRROR: mirror_upd = item.data[1:0];
                CMD_IRQ_EN: begin
                    en_upd = (item.data != 8'd0);
                    // A zero byte also acknowledges a pending interrupt.
                    if (item.data == 8'd0) begin
                        pend_upd = 1'b0;
                    end
                end
                CMD_CNT_LO: count_upd[7:0] = item.data;
                CMD_CNT_HI: count_upd[15:8] = item.data;
                default:    chr_upd[cmd_reg[2:0]] = item.data;
            endcase
        end

        if (item.func == FUNC_TICK && en_reg) begin
            if (count_reg == 16'd0) begin
                pend_upd  = 1'b1;
                en_upd    = 1'b0;
                count_upd = COUNT_RELOAD;
            end else begin
                count_upd = count_reg - 16'd1;
            end
        end
    end

    always_comb begin
        prg_mask_next = prg_mask_reg;
        chr_mask_next = chr_mask_reg;
        if (cfg_wr_en && cfg_index == CFG_PRG_MASK) begin
            prg_mask_next = cfg_wdata;
        end
        if (cfg_wr_en && cfg_index == CFG_CHR_MASK) begin
            chr_mask_next = cfg_wdata;
        end
    end

    assign cmd_next    = item_en ? cmd_upd    : cmd_reg;
    assign chr_next    = item_en ? chr_upd    : chr_reg;
    assign prg_next    = item_en ? prg_upd    : prg_reg;
    assign mirror_next = item_en ? mirror_upd : mirror_reg;
    assign work_next   = item_en ? work_upd   : work_reg;
    assign count_next  = item_en ? count_upd  : count_reg;
    assign en_next     = item_en ? en_upd     : en_reg;
    assign pend_next   = item_en ? pend_upd   : pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_mask_reg <= PRG_MASK_RST;
            chr_mask_reg <= CHR_MASK_RST;
            cmd_reg      <= 4'd0;
            chr_reg      <= '0;
            prg_reg      <= '0;
            mirror_reg   <= 2'd0;
            work_reg     <= WORK_CTRL_RST;
            count_reg    <= COUNT_RELOAD;
            en_reg       <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            prg_mask_reg <= prg_mask_next;
            chr_mask_reg <= chr_mask_next;
            cmd_reg      <= cmd_next;
            chr_reg      <= chr_next;
            prg_reg      <= prg_next;
            mirror_reg   <= mirror_next;
            work_reg     <= work_next;
            count_reg    <= count_next;
            en_reg       <= en_next;
            pend_reg     <= pend_next;
        end
    end

    assign bank_state.prg_mask  = prg_mask_reg;
    assign bank_state.chr_mask  = chr_mask_reg;
    assign bank_state.chr_bank  = chr_reg;
    assign bank_state.prg_bank  = prg_reg;
    assign bank_state.work_ctrl = work_reg;

    assign post_status.irq    = pend_upd;
    assign post_status.mirror = mirror_upd;

endmodule

[rtl/bmci_xlate.sv]
// CPU and PPU address translation from the current bank registers.
// Depends on bmci_pkg.
module bmci_xlate (
    input  bmci_pkg::in_item_t    item,
    input  bmci_pkg::bank_state_t bank_state,
    output logic [1:0]            map_kind,
    output logic [20:0]           mapped_offset
);
    import bmci_pkg::*;

    logic [2:0] win;
    logic [7:0] cpu_bank;
    logic [7:0] chr_bank;
    logic [1:0] prg_slot;

    assign win      = item.addr[15:13];
    assign prg_slot = 2'(win - WIN_CMD);
    assign chr_bank = bank_state.chr_bank[item.addr[12:10]] & bank_state.chr_mask;

    always_comb begin
        priority if (win == WIN_FIXED) begin
            cpu_bank = bank_state.prg_mask;
        end else if (win[2]) begin
            // Windows 0x8000, 0xA000 and 0xC000 map to the three switchable banks.
            cpu_bank = bank_state.prg_bank[prg_slot] & bank_state.prg_mask;
        end else begin
            cpu_bank = {2'b00, bank_state.work_ctrl[5:0]} & bank_state.prg_mask;
        end
    end

    always_comb begin
        map_kind      = KIND_OTHER;
        mapped_offset = 21'd0;
        unique case (item.func)
            FUNC_CPU: begin
                if (win >= WIN_WORK) begin
                    if (win == WIN_WORK && bank_state.work_ctrl[6]) begin
                        map_kind      = bank_state.work_ctrl[7] ? KIND_RAM_ON : KIND_RAM_OFF;
                        mapped_offset = {8'd0, item.addr[12:0]};
                    end else begin
                        map_kind      = KIND_ROM;
                        mapped_offset = {cpu_bank, item.addr[12:0]};
                    end
                end
            end
            FUNC_PPU: begin
                if (win == WIN_PPU_PAT) begin
                    mapped_offset = {3'd0, chr_bank, item.addr[9:0]};
                end
            end
            default: begin
                map_kind      = KIND_OTHER;
                mapped_offset = 21'd0;
            end
        endcase
    end

endmodule

[rtl/bank_mapper_with_cycle_irq_top.sv]
// Top level of the bank mapper with cycle interrupt counter.
// Depends on bmci_pkg, bmci_regs, bmci_xlate and the assertion macro header.
//
// Usage:
// - Input channel s_valid/s_ready/s_item carries one item per transfer: a bus
//   write, a CPU cycle tick, a CPU address lookup or a PPU address lookup.
// - Result channel m_valid/m_ready/m_item returns exactly one result per item,
//   in order: the interrupt flag and mirroring after the item, and the lookup's
//   kind and byte offset.
// - cfg_wr_en/cfg_index/cfg_wdata write the bank count masks; index 0 is the
//   program mask, index 1 the pattern mask, other indexes are ignored.
// - An item waits in the input register, where the register file update and
//   translation are done, and its result is registered into the output
//   register and shown on m_item with m_valid high.
// - Throughput is one item per cycle while results are taken; both registers
//   move in every cycle in which the output register is free or drained.
// - Reset clears both valid flags and loads the mapper registers with
//   their power-up values (masks 15 and 255, work area 0x40, count 0xFFFF).
// - When the receiver stalls the result holds, the input register keeps the
//   next item, and s_ready drops once both are full.
`include "bank_mapper_with_cycle_irq_top_assert.svh"

module bank_mapper_with_cycle_irq_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bmci_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bmci_pkg::out_item_t             m_item,
    input  logic                            cfg_wr_en,
    input  logic [bmci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmci_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bmci_pkg::*;

    logic         in_vld_reg, in_vld_next;
    in_item_t     in_item_reg, in_item_next;
    logic         out_vld_reg, out_vld_next;
    out_item_t    out_item_reg, out_item_next;
    logic         advance;
    logic         s_xfer;
    bank_state_t  bank_state;
    post_status_t post_status;
    logic [1:0]   map_kind;
    logic [20:0]  mapped_offset;

    // The held item moves on whenever the output register is free or being drained.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    bmci_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (advance),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .bank_state  (bank_state),
        .post_status (post_status)
    );

    bmci_xlate u_xlate (
        .item          (in_item_reg),
        .bank_state    (bank_state),
        .map_kind      (map_kind),
        .mapped_offset (mapped_offset)
    );

    always_comb begin
        in_vld_next   = s_xfer || (in_vld_reg && !advance);
        in_item_next  = s_xfer ? s_item : in_item_reg;
        out_vld_next  = advance || (out_vld_reg && !m_ready);
        out_item_next = out_item_reg;
        if (advance) begin
            out_item_next.irq_line      = post_status.irq;
            out_item_next.mirror_mode   = post_status.mirror;
            out_item_next.map_kind      = map_kind;
            out_item_next.mapped_offset = mapped_offset;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

    `BMCI_ASSERT(a_hold_blocked, aclk, aresetn, in_vld_reg && !advance |=> in_vld_reg && $stable(in_item_reg), "blocked input item was lost or changed")
    `BMCI_ASSERT(a_result_loaded, aclk, aresetn, advance |=> out_vld_reg, "processed item left no result")
    `BMCI_ASSERT(a_irq_from_tick, aclk, aresetn, $rose(m_item.irq_line) && m_valid |-> $past(advance), "interrupt flag changed without a transfer")
    `BMCI_ASSERT(a_kind_nonlookup, aclk, aresetn, advance && in_item_reg.func != FUNC_CPU |=> m_item.map_kind == KIND_OTHER, "non-CPU item returned a program or work area kind")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bank_mapper_with_cycle_irq_top: a directed table, then
// random bus writes, timer ticks and lookups, checked by typed-in or predicted results.
// Depends on bmci_pkg and the RTL of the mapper only.
module testbench;
    import bmci_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          RANDOM_PHASES = 6;
    localparam int          ITEMS_PER_PHASE = 304;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        in_item_t  item;
        logic      fixed_res;
        out_item_t result;
    } walk_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b1;
    out_item_t m_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the mapper state and the bank masks.
    logic [7:0]  prg_mask = PRG_MASK_RST;
    logic [7:0]  chr_mask = CHR_MASK_RST;
    logic [3:0]  cmd_sel = 4'h0;
    logic [7:0]  prg_regs [PRG_SLOTS] = '{default: 8'h00};
    logic [7:0]  chr_regs [CHR_SLOTS] = '{default: 8'h00};
    logic [1:0]  mirror_sel = 2'd0;
    logic [7:0]  work_ctrl = WORK_CTRL_RST;
    logic [15:0] timer_left = COUNT_RELOAD;
    logic        irq_armed = 1'b0;
    logic        irq_flag = 1'b0;

    out_item_t   expected_results [$];
    out_item_t   want_res;
    int          mismatches = 0;
    int          sent_items = 0;
    int          idle_odds = 0;
    int unsigned cycles_run = 0;

    // Rows up to the first mirroring write run with reset state, so their
    // results are typed in; the rest go through the predictor.
    walk_row_t walk_rows [26] = '{
        '{'{FUNC_CPU,   16'h0000, 8'h00}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_CPU,   16'h6000, 8'hFF}, 1'b1, '{1'b0, 2'd0, KIND_RAM_OFF, 21'h00000}},
        '{'{FUNC_CPU,   16'h7FFF, 8'h00}, 1'b1, '{1'b0, 2'd0, KIND_RAM_OFF, 21'h01FFF}},
        '{'{FUNC_CPU,   16'h8000, 8'hFF}, 1'b1, '{1'b0, 2'd0, KIND_ROM,     21'h00000}},
        '{'{FUNC_CPU,   16'hFFFF, 8'h00}, 1'b1, '{1'b0, 2'd0, KIND_ROM,     21'h1FFFF}},
        '{'{FUNC_PPU,   16'h0000, 8'hFF}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_PPU,   16'h1FFF, 8'h00}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h003FF}},
        '{'{FUNC_PPU,   16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_TICK,  16'h0000, 8'h00}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_WRITE, 16'hC000, 8'hFF}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_WRITE, 16'h7FFF, 8'h0D}, 1'b1, '{1'b0, 2'd0, KIND_OTHER,   21'h00000}},
        '{'{FUNC_WRITE, 16'h9FFF, 8'hFC}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'h03}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'h8000, 8'h0E}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hBFFF, 8'h00}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'h8000, 8'h0F}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'h00}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'h8000, 8'h0D}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'h01}, 1'b0, '0},
        '{'{FUNC_TICK,  16'hFFFF, 8'hFF}, 1'b0, '0},
        '{'{FUNC_TICK,  16'h0000, 8'h00}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'h00}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'h8000, 8'h08}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'hC0}, 1'b0, '0},
        '{'{FUNC_CPU,   16'h6ABC, 8'h00}, 1'b0, '0},
        '{'{FUNC_WRITE, 16'hA000, 8'h3F}, 1'b0, '0}
    };

    bank_mapper_with_cycle_irq_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Applies one item to the predictor state and returns the result it causes.
    function automatic out_item_t predict_mapping(input in_item_t it);
        out_item_t  r;
        logic [7:0] bank;
        bank = 8'h00;
        r.map_kind = KIND_OTHER;
        r.mapped_offset = '0;
        case (it.func)
            FUNC_WRITE: begin
                if (it.addr >= 16'h8000 && it.addr < 16'hA000) begin
                    cmd_sel = it.data[3:0];
                end else if (it.addr >= 16'hA000 && it.addr < 16'hC000) begin
                    case (cmd_sel)
                        CMD_IRQ_EN: begin
                            irq_armed = (it.data != 8'h00);
                            if (it.data == 8'h00) irq_flag = 1'b0;
                        end
                        CMD_CNT_LO: timer_left[7:0] = it.data;
                        CMD_CNT_HI: timer_left[15:8] = it.data;
                        CMD_MIRROR: mirror_sel = it.data[1:0];
                        CMD_PRG0:   prg_regs[0] = it.data;
                        CMD_PRG1:   prg_regs[1] = it.data;
                        CMD_PRG2:   prg_regs[2] = it.data;
                        CMD_WORK:   work_ctrl = it.data;
                        default:    chr_regs[cmd_sel[2:0]] = it.data;
                    endcase
                end
            end
            FUNC_TICK: begin
                if (irq_armed) begin
                    if (timer_left == 16'h0000) begin
                        irq_flag = 1'b1;
                        irq_armed = 1'b0;
                        timer_left = COUNT_RELOAD;
                    end else begin
                        timer_left = timer_left - 16'd1;
                    end
                end
            end
            FUNC_CPU: begin
                if (it.addr >= 16'h6000) begin
                    r.map_kind = KIND_ROM;
                    if (it.addr < 16'h8000) begin
                        // Work RAM keeps bank zero, so its offset is the low 13 bits.
                        if (work_ctrl[6])
                            r.map_kind = work_ctrl[7] ? KIND_RAM_ON : KIND_RAM_OFF;
                        else
                            bank = {2'b00, work_ctrl[5:0]} & prg_mask;
                    end else if (it.addr < 16'hE000) begin
                        bank = prg_regs[it.addr[14:13]] & prg_mask;
                    end else begin
                        bank = prg_mask;
                    end
                    r.mapped_offset = {bank, it.addr[12:0]};
                end
            end
            FUNC_PPU: begin
                if (it.addr < 16'h2000)
                    r.mapped_offset = {3'b000, chr_regs[it.addr[12:10]] & chr_mask,
                                       it.addr[9:0]};
            end
        endcase
        r.irq_line = irq_flag;
        r.mirror_mode = mirror_sel;
        return r;
    endfunction

    task automatic send_item(input in_item_t it, input logic fixed_res = 1'b0,
                             input out_item_t fixed_val = '0);
        out_item_t predicted;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        predicted = predict_mapping(it);
        expected_results.push_back(fixed_res ? fixed_val : predicted);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Command write followed by the data write that loads the selected register.
    task automatic load_mapper_reg(input logic [3:0] cmd, input logic [7:0] val);
        send_item('{FUNC_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h1FFF)),
                    {4'($urandom), cmd}});
        send_item('{FUNC_WRITE, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), val});
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_PRG_MASK)
            prg_mask = val;
        else if (idx == CFG_CHR_MASK)
            chr_mask = val;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_burst();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: send_item('{FUNC_CPU, 16'($urandom), 8'($urandom)});
            3, 4: begin
                if ($urandom_range(0, 7) == 0)
                    send_item('{FUNC_PPU, 16'($urandom), 8'($urandom)});
                else
                    send_item('{FUNC_PPU, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom)});
            end
            5, 6: load_mapper_reg(4'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            7: begin
                // Arm the timer with a mostly short count and send it 0 to 30 ticks.
                load_mapper_reg(CMD_CNT_LO, 8'($urandom_range(0, 24)));
                load_mapper_reg(CMD_CNT_HI, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
                load_mapper_reg(CMD_IRQ_EN, 8'($urandom_range(1, 255)));
                n = $urandom_range(0, 30);
                repeat (n) send_item('{FUNC_TICK, 16'($urandom), 8'($urandom)});
            end
            8: begin
                n = $urandom_range(1, 4);
                repeat (n) send_item('{FUNC_TICK, 16'($urandom), 8'($urandom)});
            end
            default: send_item(in_item_t'(26'($urandom)));
        endcase
    endtask

    task automatic report_field(input string name, input logic [20:0] want,
                                input logic [20:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, m_item);
                mismatches++;
            end else begin
                want_res = expected_results.pop_front();
                if (m_item.irq_line !== want_res.irq_line)
                    report_field("irq_line", 21'(want_res.irq_line), 21'(m_item.irq_line));
                if (m_item.mirror_mode !== want_res.mirror_mode)
                    report_field("mirror_mode", 21'(want_res.mirror_mode),
                                 21'(m_item.mirror_mode));
                if (m_item.map_kind !== want_res.map_kind)
                    report_field("map_kind", 21'(want_res.map_kind), 21'(m_item.map_kind));
                if (m_item.mapped_offset !== want_res.mapped_offset)
                    report_field("mapped_offset", want_res.mapped_offset, m_item.mapped_offset);
            end
        end
    end

    // Receiver stalls come in bursts, at a rate that changes with the phase.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int         ph;
        int         item_goal;
        logic [7:0] pm;
        logic [7:0] cm;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_odds = 5;
        foreach (walk_rows[i])
            send_item(walk_rows[i].item, walk_rows[i].fixed_res, walk_rows[i].result);

        sent_items = 0;
        item_goal = 0;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    idle_odds = 12;
                    write_mask(CFG_SPARE_A, 8'($urandom));
                    write_mask(CFG_SPARE_B, 8'($urandom));
                    pm = PRG_MASK_RST;
                    cm = CHR_MASK_RST;
                end
                1: begin
                    idle_odds = 3;
                    pm = 8'h00;
                    cm = 8'h00;
                end
                2: begin
                    idle_odds = 30;
                    pm = 8'hFF;
                    cm = 8'hFF;
                end
                RANDOM_PHASES - 1: begin
                    idle_odds = 0;
                    pm = 8'hFF;
                    cm = 8'h00;
                end
                default: begin
                    idle_odds = 8;
                    pm = 8'((1 << $urandom_range(0, 8)) - 1);
                    cm = 8'((1 << $urandom_range(0, 8)) - 1);
                end
            endcase
            write_mask(CFG_PRG_MASK, pm);
            write_mask(CFG_CHR_MASK, cm);
            item_goal += ITEMS_PER_PHASE;
            while (sent_items < item_goal) run_burst();
        end

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/bmci_pkg.sv
rtl/bmci_regs.sv
rtl/bmci_xlate.sv
rtl/bank_mapper_with_cycle_irq_top.sv
sim/testbench.sv
